// ===== rtl/kti_pkg.sv =====
// kti_pkg: widths, constants and shared types of the k-space trajectory integrator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package kti_pkg;

  localparam int GRAD_W      = 24;
  localparam int IDX_W       = 20;
  localparam int TS_W        = 16;
  localparam int ACC_W       = 40;
  localparam int SCALE_SHIFT = 8;
  localparam int Q_W         = ACC_W - SCALE_SHIFT;
  localparam int SQ_W        = 2 * Q_W;
  localparam int ROOT_W      = Q_W;
  localparam int MAG_W       = 33;
  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;

  localparam logic [TS_W-1:0] TS_RESET = TS_W'(160);

  // power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  // one classified item as it sits in the queue
  typedef struct packed {
    logic [AXES-1:0][GRAD_W-1:0] grad;
    logic                        restart;
    logic                        clear;
    logic                        negate;
    logic                        wopen;
    logic                        wclose;
  } item_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/kspace_trajectory_integrator.sv =====
// Integrates a three-axis gradient stream into a k-space trajectory and reports,
// per acquisition window, the earliest sample of smallest |k|. Input items are
// classified and held in a four-entry queue, so the input side keeps taking
// transfers until the queue is full, while the back end works or the output waits.
// The back end fetches an item, integrates each axis, then squares and sums each
// axis and takes the square root, which produces one bit per cycle; a first_sample
// item goes straight to the finishing state. One result leaves for each item, held
// in an output register until taken. time_step may be written only while idle.
// uses kti_pkg, kti_front, kti_queue, kti_back (with kti_sqrt)
`timescale 1ns / 1ps
`default_nettype none

module kspace_trajectory_integrator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [kti_pkg::TS_W-1:0]    cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_x,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_y,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_z,
  input  wire logic                        first_sample,
  input  wire logic                        excite,
  input  wire logic [1:0]                  refocus_count,
  input  wire logic                        window_open,
  input  wire logic                        window_close,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [kti_pkg::IDX_W-1:0]        sample_index,
  output logic [kti_pkg::MAG_W-1:0]        k_magnitude,
  output logic                             window_done,
  output logic [kti_pkg::IDX_W-1:0]        window_min_index,
  output logic [kti_pkg::MAG_W-1:0]        window_min_magnitude,
  output logic                             saturated
);
  import kti_pkg::*;

  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  queue_full;
  logic  queue_empty;

  kti_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .grad_z        (grad_z),
    .first_sample  (first_sample),
    .excite        (excite),
    .refocus_count (refocus_count),
    .window_open   (window_open),
    .window_close  (window_close),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  kti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  kti_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .head                 (head),
    .queue_empty          (queue_empty),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .sample_index         (sample_index),
    .k_magnitude          (k_magnitude),
    .window_done          (window_done),
    .window_min_index     (window_min_index),
    .window_min_magnitude (window_min_magnitude),
    .saturated            (saturated)
  );

  // window fields are zero unless a window closed on this result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_done |-> window_min_index == '0 && window_min_magnitude == '0)
    else $error("window fields set without a closed window");

  // the closing sample belongs to the window, so the minimum cannot exceed it
  assert property (@(posedge clk) disable iff (rst)
    out_valid && window_done |-> window_min_magnitude <= k_magnitude)
    else $error("window minimum above closing sample magnitude");

  // the root of a sum of three squared 32-bit values stays below 2^32
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !k_magnitude[MAG_W-1])
    else $error("magnitude out of range");

  // a queue pop only happens when an entry is present
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/kti_front.sv =====
// kti_front: input transfer and classification of each sample into a queue entry
// uses kti_pkg; feeds kti_queue
`timescale 1ns / 1ps
`default_nettype none

module kti_front (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_x,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_y,
  input  wire logic [kti_pkg::GRAD_W-1:0]  grad_z,
  input  wire logic                        first_sample,
  input  wire logic                        excite,
  input  wire logic [1:0]                  refocus_count,
  input  wire logic                        window_open,
  input  wire logic                        window_close,
  input  wire logic                        queue_full,
  output logic                             push,
  output kti_pkg::item_t                   push_item
);
  import kti_pkg::*;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.grad[0] = grad_x;
    push_item.grad[1] = grad_y;
    push_item.grad[2] = grad_z;
    push_item.restart = first_sample;
    // excite and refocus are ignored on a restart; an even refocus count cancels out
    push_item.clear   = excite && !first_sample;
    push_item.negate  = refocus_count[0] && !first_sample;
    push_item.wopen   = window_open;
    push_item.wclose  = window_close;
  end

endmodule

`default_nettype wire

// ===== rtl/kti_queue.sv =====
// kti_queue: short fifo of classified items between front and back
// uses kti_pkg
`timescale 1ns / 1ps
`default_nettype none

module kti_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire kti_pkg::item_t push_item,
  input  wire logic    pop,
  output kti_pkg::item_t head,
  output logic         full,
  output logic         empty
);
  import kti_pkg::*;

  item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      if (push && !pop)      count <= count + QUEUE_CNT_W'(1);
      else if (pop && !push) count <= count - QUEUE_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kti_sqrt.sv =====
// kti_sqrt: iterative integer square root, one result bit per cycle
// uses kti_pkg; instantiated by kti_back
`timescale 1ns / 1ps
`default_nettype none

module kti_sqrt (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kti_pkg::sqrt_req_t req,
  output kti_pkg::sqrt_rsp_t rsp
);
  import kti_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   radicand;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic              done;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              take;

  always_comb begin
    rem_shift = {rem[REM_W-3:0], radicand[SQ_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    take      = (rem_shift >= trial);
  end

  assign rsp.done = done;
  assign rsp.root = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(ROOT_W - 1));
      if (req.start && !busy) begin
        busy     <= 1'b1;
        cnt      <= '0;
        radicand <= req.radicand;
        rem      <= '0;
        root     <= '0;
      end else if (busy) begin
        radicand <= {radicand[SQ_W-3:0], 2'b00};
        if (take) begin
          rem  <= rem_shift - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kti_back.sv =====
// kti_back: sequencer that integrates each axis, forms the magnitude and tracks windows
// uses kti_pkg and kti_sqrt; takes items from kti_queue
`timescale 1ns / 1ps
`default_nettype none

module kti_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kti_pkg::TS_W-1:0]      cfg_data,
  input  wire kti_pkg::item_t                head,
  input  wire logic                          queue_empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [kti_pkg::IDX_W-1:0]          sample_index,
  output logic [kti_pkg::MAG_W-1:0]          k_magnitude,
  output logic                               window_done,
  output logic [kti_pkg::IDX_W-1:0]          window_min_index,
  output logic [kti_pkg::MAG_W-1:0]          window_min_magnitude,
  output logic                               saturated
);
  import kti_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQ,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

  localparam int PROD_W = GRAD_W + TS_W + 2;
  localparam int KSUM_W = ACC_W + 2;
  localparam logic signed [KSUM_W-1:0] KSUM_MAX = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [KSUM_W-1:0] KSUM_MIN = {3'b111, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [MAG_W-1:0] MAG_ONES = {MAG_W{1'b1}};

  state_t                          state;
  item_t                           item;
  logic [AXIS_W-1:0]               axis;
  logic [TS_W-1:0]                 time_step;
  logic [AXES-1:0][GRAD_W-1:0]     prev_grad;
  logic [AXES-1:0][ACC_W-1:0]      k_acc;
  logic signed [PROD_W-1:0]        prod;
  logic [SQ_W-1:0]                 sq;
  logic [SQ_W-1:0]                 sumsq;
  logic                            sat;
  logic [MAG_W-1:0]                mag;
  logic [IDX_W-1:0]                counter;
  logic                            win_active;
  logic [MAG_W-1:0]                run_min;
  logic [IDX_W-1:0]                run_idx;

  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  kti_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // trapezoid step for the current axis
  logic signed [GRAD_W:0]    grad_sum;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [KSUM_W-1:0]  ksum;
  logic [ACC_W-1:0]          k_clamped;
  logic [ACC_W-1:0]          k_next;
  logic                      sat_next;
  logic signed [Q_W-1:0]     q;
  logic signed [SQ_W-1:0]    sq_full;
  logic [SQ_W-1:0]           sumsq_next;

  always_comb begin
    grad_sum  = $signed({prev_grad[axis][GRAD_W-1], prev_grad[axis]})
              + $signed({item.grad[axis][GRAD_W-1], item.grad[axis]});
    prod_next = grad_sum * $signed({1'b0, time_step});
    // floor of half the product
    ksum      = $signed({{2{k_acc[axis][ACC_W-1]}}, k_acc[axis]})
              + KSUM_W'(prod >>> 1);
    sat_next  = sat;
    if (ksum > KSUM_MAX) begin
      k_clamped = ACC_MAX;
      sat_next  = 1'b1;
    end else if (ksum < KSUM_MIN) begin
      k_clamped = ACC_MIN;
      sat_next  = 1'b1;
    end else begin
      k_clamped = ksum[ACC_W-1:0];
    end
    k_next = item.clear ? '0 : k_clamped;
    if (item.negate) begin
      if (k_next == ACC_MIN) begin
        k_next   = ACC_MAX;
        sat_next = 1'b1;
      end else begin
        k_next = -k_next;
      end
    end
    q          = $signed(k_acc[axis][ACC_W-1:SCALE_SHIFT]);
    sq_full    = q * q;
    sumsq_next = sumsq + sq;
  end

  always_comb begin
    sqrt_req.start    = (state == ST_SUM) && (axis == AXIS_W'(AXES - 1));
    sqrt_req.radicand = sumsq_next;
  end

  // window tracking and output formation for the finishing item
  logic             out_free;
  logic [IDX_W-1:0] idx;
  logic             wa_next;
  logic [MAG_W-1:0] min_next;
  logic [IDX_W-1:0] min_idx_next;
  logic             done_next;
  logic [IDX_W-1:0] done_idx;
  logic [MAG_W-1:0] done_mag;
  logic [IDX_W-1:0] counter_next;

  always_comb begin
    out_free     = !out_valid || !out_stall;
    idx          = item.restart ? '0 : counter;
    wa_next      = item.restart ? 1'b0 : win_active;
    min_next     = item.restart ? MAG_ONES : run_min;
    min_idx_next = item.restart ? '0 : run_idx;
    if (item.wopen) begin
      wa_next      = 1'b1;
      min_next     = mag;
      min_idx_next = idx;
    end else if (wa_next && mag < min_next) begin
      min_next     = mag;
      min_idx_next = idx;
    end
    done_next = item.wclose && wa_next;
    done_idx  = '0;
    done_mag  = '0;
    if (done_next) begin
      done_idx     = min_idx_next;
      done_mag     = min_next;
      wa_next      = 1'b0;
      min_next     = MAG_ONES;
      min_idx_next = '0;
    end
    counter_next = (idx < IDX_MAX) ? idx + IDX_W'(1) : idx;
  end

  assign pop = (state == ST_IDLE) && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      time_step  <= TS_RESET;
      prev_grad  <= '0;
      k_acc      <= '0;
      counter    <= '0;
      win_active <= 1'b0;
      run_min    <= MAG_ONES;
      run_idx    <= '0;
      out_valid  <= 1'b0;
      axis       <= '0;
    end else begin
      if (cfg_we) time_step <= cfg_data;
      // the finishing state reloads the output register itself
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            item  <= head;
            axis  <= '0;
            sat   <= 1'b0;
            sumsq <= '0;
            mag   <= '0;
            state <= head.restart ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= prod_next;
          state <= ST_ACC;
        end
        ST_ACC: begin
          k_acc[axis] <= k_next;
          sat         <= sat_next;
          if (axis == AXIS_W'(AXES - 1)) begin
            axis  <= '0;
            state <= ST_SQ;
          end else begin
            axis  <= axis + AXIS_W'(1);
            state <= ST_MUL;
          end
        end
        ST_SQ: begin
          sq    <= $unsigned(sq_full);
          state <= ST_SUM;
        end
        ST_SUM: begin
          sumsq <= sumsq_next;
          if (axis == AXIS_W'(AXES - 1)) begin
            state <= ST_ROOT;
          end else begin
            axis  <= axis + AXIS_W'(1);
            state <= ST_SQ;
          end
        end
        ST_ROOT: begin
          if (sqrt_rsp.done) begin
            mag   <= MAG_W'(sqrt_rsp.root);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            sample_index         <= idx;
            k_magnitude          <= mag;
            window_done          <= done_next;
            window_min_index     <= done_idx;
            window_min_magnitude <= done_mag;
            saturated            <= sat;
            prev_grad            <= item.grad;
            if (item.restart) k_acc <= '0;
            counter              <= counter_next;
            win_active           <= wa_next;
            run_min              <= min_next;
            run_idx              <= min_idx_next;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
